/* hdl/t16sb_pkg.sv */
// Shared constants, codes and types of the subtile blitter.
`default_nettype none

package t16sb_pkg;

    localparam int SHEET_BYTES = 32768;
    localparam int MAX_BLOCKS = 4096;
    localparam int SHEET_AW = $clog2(SHEET_BYTES);

    localparam int KIND_W = 1;
    localparam int SADDR_W = 15;
    localparam int SBYTE_W = 8;
    localparam int TILE_W = 10;
    localparam int PAL_W = 3;
    localparam int QUAD_W = 2;
    localparam int BLOCK_W = 12;
    localparam int PIX_AW = 20;
    localparam int PIX_VW = 7;
    localparam int BYTE_IDX_W = 5;

    localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
    localparam logic [KIND_W-1:0] KIND_RENDER = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_RENDER
    } t16sb_state_t;

    typedef struct packed {
        logic [PIX_AW-2:0] addr_hi;
        logic [PAL_W-1:0]  pal;
        logic              hflip;
        logic              last;
        logic              oob;
    } t16sb_byte_ctx_t;

    typedef struct packed {
        logic            issue;
        t16sb_byte_ctx_t ctx;
    } t16sb_rd_req_t;

endpackage

`default_nettype wire

/* hdl/t16sb_if.sv */
// Handshake channel interfaces for the blitter requests and pixel writes.
`default_nettype none

interface t16sb_in_if;
    logic                            valid;
    logic                            ready;
    logic [t16sb_pkg::KIND_W-1:0]    kind;
    logic [t16sb_pkg::SADDR_W-1:0]   sheet_address;
    logic [t16sb_pkg::SBYTE_W-1:0]   sheet_byte;
    logic [t16sb_pkg::TILE_W-1:0]    tile_id;
    logic [t16sb_pkg::PAL_W-1:0]     palette_number;
    logic                            flip_horizontal;
    logic                            flip_vertical;
    logic [t16sb_pkg::QUAD_W-1:0]    quadrant;
    logic [t16sb_pkg::BLOCK_W-1:0]   block_index;

    modport source (
        output valid, kind, sheet_address, sheet_byte, tile_id, palette_number,
               flip_horizontal, flip_vertical, quadrant, block_index,
        input  ready
    );
    modport sink (
        input  valid, kind, sheet_address, sheet_byte, tile_id, palette_number,
               flip_horizontal, flip_vertical, quadrant, block_index,
        output ready
    );
endinterface

interface t16sb_out_if;
    logic                          valid;
    logic                          ready;
    logic [t16sb_pkg::PIX_AW-1:0]  pixel_address;
    logic [t16sb_pkg::PIX_VW-1:0]  pixel_value;
    logic                          last_pixel;

    modport source (
        output valid, pixel_address, pixel_value, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_address, pixel_value, last_pixel,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/t16sb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module t16sb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/t16sb_ctrl.sv */
// Request sequencer: stores sheet bytes and walks the 32 bytes of a subtile.
`default_nettype none

module t16sb_ctrl (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    t16sb_in_if.sink                                items,
    input  wire logic                               can_issue,
    output t16sb_pkg::t16sb_rd_req_t                req,
    output logic                                    we,
    output logic [t16sb_pkg::SHEET_AW-1:0]          waddr,
    output logic [t16sb_pkg::SBYTE_W-1:0]           wdata,
    output logic [t16sb_pkg::SHEET_AW-1:0]          raddr
);

    t16sb_pkg::t16sb_state_t state_reg, state_next;
    logic [t16sb_pkg::BYTE_IDX_W-1:0] idx_reg, idx_next;

    logic [t16sb_pkg::TILE_W-1:0]  tile_reg;
    logic [t16sb_pkg::PAL_W-1:0]   pal_reg;
    logic                          hflip_reg;
    logic                          vflip_reg;
    logic [t16sb_pkg::QUAD_W-1:0]  quad_reg;
    logic [t16sb_pkg::BLOCK_W-1:0] block_reg;

    logic                          accept;
    logic                          start;
    logic [2:0]                    row;
    logic [1:0]                    col;
    logic [2:0]                    mrow;
    logic [1:0]                    mcol;
    logic [t16sb_pkg::SADDR_W-1:0] src_addr;

    assign accept = items.valid && items.ready;
    assign start = accept && (items.kind == t16sb_pkg::KIND_RENDER)
                   && (32'(items.block_index) < t16sb_pkg::MAX_BLOCKS);

    assign row = idx_reg[4:2];
    assign col = idx_reg[1:0];
    assign mrow = vflip_reg ? ~row : row;
    assign mcol = hflip_reg ? ~col : col;
    assign src_addr = {tile_reg[9:4], row, tile_reg[3:0], col};

    assign we = accept && (items.kind == t16sb_pkg::KIND_LOAD)
                && (32'(items.sheet_address) < t16sb_pkg::SHEET_BYTES);
    assign waddr = t16sb_pkg::SHEET_AW'(items.sheet_address);
    assign wdata = items.sheet_byte;
    assign raddr = t16sb_pkg::SHEET_AW'(src_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= t16sb_pkg::ST_IDLE;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            tile_reg <= items.tile_id;
            pal_reg <= items.palette_number;
            hflip_reg <= items.flip_horizontal;
            vflip_reg <= items.flip_vertical;
            quad_reg <= items.quadrant;
            block_reg <= items.block_index;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        items.ready = 1'b0;
        req.issue = 1'b0;
        req.ctx.addr_hi = {block_reg[11:3], quad_reg[1], mrow, block_reg[2:0],
                           quad_reg[0], mcol};
        req.ctx.pal = pal_reg;
        req.ctx.hflip = hflip_reg;
        req.ctx.last = &idx_reg;
        req.ctx.oob = !(32'(src_addr) < t16sb_pkg::SHEET_BYTES);
        case (state_reg)
            t16sb_pkg::ST_IDLE:
            begin
                items.ready = 1'b1;
                idx_next = '0;
                if (start)
                begin
                    state_next = t16sb_pkg::ST_RENDER;
                end
            end
            t16sb_pkg::ST_RENDER:
            begin
                if (can_issue)
                begin
                    req.issue = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    if (&idx_reg)
                    begin
                        state_next = t16sb_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = t16sb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/t16sb_emit.sv */
// Pixel emitter: takes sheet bytes from the RAM and sends two pixels per byte.
`default_nettype none

module t16sb_emit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire t16sb_pkg::t16sb_rd_req_t        req,
    input  wire logic [t16sb_pkg::SBYTE_W-1:0]   rdata,
    output logic                                 can_issue,
    t16sb_out_if.source                          pixels
);

    logic                          rdv_reg;
    t16sb_pkg::t16sb_byte_ctx_t    rctx_reg;

    logic                          hold_valid_reg;
    logic                          hold_phase_reg;
    logic [t16sb_pkg::SBYTE_W-1:0] hold_byte_reg;
    t16sb_pkg::t16sb_byte_ctx_t    hold_ctx_reg;

    logic                          out_valid_reg;
    logic [t16sb_pkg::PIX_AW-1:0]  out_addr_reg;
    logic [t16sb_pkg::PIX_VW-1:0]  out_value_reg;
    logic                          out_last_reg;

    logic                          out_free;
    logic                          hold_move;
    logic                          hold_free;
    logic                          load;
    logic [3:0]                    nibble;

    assign out_free = !out_valid_reg || pixels.ready;
    assign hold_move = hold_valid_reg && out_free;
    assign hold_free = !hold_valid_reg || (hold_move && hold_phase_reg);
    assign load = rdv_reg && hold_free;
    assign can_issue = !rdv_reg || load;
    assign nibble = hold_phase_reg ? hold_byte_reg[7:4] : hold_byte_reg[3:0];

    assign pixels.valid = out_valid_reg;
    assign pixels.pixel_address = out_addr_reg;
    assign pixels.pixel_value = out_value_reg;
    assign pixels.last_pixel = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdv_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
            hold_phase_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rdv_reg <= req.issue || (rdv_reg && !load);
            if (load)
            begin
                hold_valid_reg <= 1'b1;
                hold_phase_reg <= 1'b0;
            end
            else if (hold_move)
            begin
                hold_valid_reg <= !hold_phase_reg;
                hold_phase_reg <= 1'b1;
            end
            if (out_free)
            begin
                out_valid_reg <= hold_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.issue)
        begin
            rctx_reg <= req.ctx;
        end
        if (load)
        begin
            hold_byte_reg <= rctx_reg.oob ? '0 : rdata;
            hold_ctx_reg <= rctx_reg;
        end
        if (hold_move)
        begin
            out_addr_reg <= {hold_ctx_reg.addr_hi,
                             ~(hold_phase_reg ^ hold_ctx_reg.hflip)};
            out_value_reg <= {hold_ctx_reg.pal, nibble};
            out_last_reg <= hold_ctx_reg.last && hold_phase_reg;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        req.issue |-> can_issue)
        else $error("read issued over an unconsumed byte");

    a_load_starts_low: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> hold_valid_reg && !hold_phase_reg)
        else $error("loaded byte does not start with its low nibble");

    a_low_then_high: assert property (@(posedge clk) disable iff (!rst_n)
        hold_move && !hold_phase_reg |=> hold_valid_reg && hold_phase_reg)
        else $error("high nibble lost after low nibble");

    a_data_from_issue: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rdv_reg) |-> $past(req.issue))
        else $error("byte marked pending without a read");

endmodule

`default_nettype wire

/* hdl/tile16_subtile_blitter.sv */
// Top level: subtile blitter from a 4bpp tile sheet to a block sheet of 7-bit pixels.
// A load request writes one byte of the sheet RAM and gives no pixels.
// A render request reads its 32 bytes through the read-data, hold and output registers
// and gives 64 pixels; a byte is read while the previous one is still being sent.
// A new request is taken once all 32 reads of the previous render are issued.
// Reset clears the control state only; sheet contents stay undefined until written.
`default_nettype none

module tile16_subtile_blitter (
    input  wire logic   clk,
    input  wire logic   rst_n,
    t16sb_in_if.sink    items,
    t16sb_out_if.source pixels
);

    t16sb_pkg::t16sb_rd_req_t            req;
    logic                                can_issue;
    logic                                we;
    logic [t16sb_pkg::SHEET_AW-1:0]      waddr;
    logic [t16sb_pkg::SBYTE_W-1:0]       wdata;
    logic [t16sb_pkg::SHEET_AW-1:0]      raddr;
    logic [t16sb_pkg::SBYTE_W-1:0]       rdata;

    t16sb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .can_issue (can_issue),
        .req       (req),
        .we        (we),
        .waddr     (waddr),
        .wdata     (wdata),
        .raddr     (raddr)
    );

    t16sb_ram #(
        .WIDTH (t16sb_pkg::SBYTE_W),
        .DEPTH (t16sb_pkg::SHEET_BYTES)
    ) u_sheet (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (req.issue),
        .raddr (raddr),
        .rdata (rdata)
    );

    t16sb_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rdata     (rdata),
        .can_issue (can_issue),
        .pixels    (pixels)
    );

endmodule

`default_nettype wire
